### design/mrap_pkg.sv
package mrap_pkg;

	// Control sequencer states, one-hot
	typedef enum logic [15:0] {
		S_INIT      = 16'h0001,
		S_IDLE      = 16'h0002,
		S_FIT_INIT  = 16'h0004,
		S_FIT       = 16'h0008,
		S_FIT_END   = 16'h0010,
		S_CMP       = 16'h0020,
		S_PUSH_A    = 16'h0040,
		S_PUSH_B    = 16'h0080,
		S_PLACE     = 16'h0100,
		S_PIECE_RD  = 16'h0200,
		S_PIECE_WT  = 16'h0400,
		S_PIECE     = 16'h0800,
		S_OUT_RD    = 16'h1000,
		S_OUT_WT    = 16'h2000,
		S_INNER     = 16'h4000,
		S_RESULT    = 16'h8000
	} state_t;

	// What a compaction pass is serving
	typedef enum logic [1:0] {
		CTX_GROW = 2'd0,
		CTX_PRE  = 2'd1,
		CTX_POST = 2'd2
	} ctx_t;

	// Split pieces in the order they are pushed
	typedef enum logic [1:0] {
		PC_ABOVE = 2'd0,
		PC_BELOW = 2'd1,
		PC_LEFT  = 2'd2,
		PC_RIGHT = 2'd3
	} piece_t;

	localparam logic [1:0] STAT_PLACED = 2'd0;
	localparam logic [1:0] STAT_NOFIT  = 2'd1;
	localparam logic [1:0] STAT_OVF    = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_CAP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_GROW = 1'd1;

endpackage

### design/mrap_ram.sv
module mrap_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// Write one word, read one word registered (old data on a same-address hit)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/maxrects_atlas_packer.sv
// Rectangle packer for a square atlas that grows by doubling.
// Request channel: req_valid / req_stall carry rect_width and rect_height; one
// request is taken at a time and req_stall stays high until its result is built.
// Result channel: res_valid / res_stall carry status, position, rotation, atlas
// size and free-list fill; the result sits in an output register, so the packer
// takes the next request while that result still waits on res_stall.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 sets
// size_cap and cleans the free list (cfg_ready low until done), index 1 sets
// auto_grow. Config is taken only while idle with no request offered.
// Per request the packer runs a search over the free list, a split pass, a piece
// step per overlapped entry, compaction passes and a pairwise containment check;
// each doubling of the atlas adds a compaction pass and two new entries. The
// passes walk the free-list memory through its single read port, one entry per
// cycle.
// Reset: one cycle after arst_n rises to write the whole-atlas entry; the block
// then takes requests. The atlas restarts at START_SIZE square.
module maxrects_atlas_packer #(
	parameter int MAX_ATLAS  = 4096,
	parameter int START_SIZE = 32,
	parameter int FREE_SLOTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [12:0]                      rect_width,
	input  logic [12:0]                      rect_height,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [1:0]                       status,
	output logic [11:0]                      pos_x,
	output logic [11:0]                      pos_y,
	output logic                             rotated,
	output logic [12:0]                      atlas_width,
	output logic [12:0]                      atlas_height,
	output logic [8:0]                       free_count,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mrap_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [12:0]                      cfg_data
);

	localparam int CW = (($clog2(MAX_ATLAS) + 1) > 13) ? ($clog2(MAX_ATLAS) + 1) : 13;
	localparam int SW = CW + 1;
	localparam int AW = $clog2(FREE_SLOTS);
	localparam int NW = AW + 1;
	localparam int EW = 4 * CW + 3;

	typedef struct packed {
		logic          dead;
		logic          ow;
		logic          oh;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] w;
		logic [CW-1:0] h;
	} ent_t;

	function automatic logic small_f(ent_t e, logic [12:0] cap);
		logic [CW-1:0] c;
		c = CW'(cap);
		return (e.w < c && !e.ow) || (e.h < c && !e.oh);
	endfunction

	function automatic logic holds_f(ent_t p, ent_t c);
		return c.x >= p.x && c.y >= p.y &&
			(c.x + c.w) <= (p.x + p.w) && (c.y + c.h) <= (p.y + p.h);
	endfunction

	// Control and state registers
	mrap_pkg::state_t state_q;
	mrap_pkg::ctx_t   ctx_q;
	mrap_pkg::piece_t piece_q;
	logic          clean_cfg_q;
	logic [NW-1:0] used_q;
	logic [CW-1:0] cur_w_q, cur_h_q;
	logic [12:0]   cap_q;
	logic          grow_en_q;
	logic          lost_q, placed_q;
	logic [CW-1:0] rw_q, rh_q;
	logic          best_found_q, best_rot_q;
	logic [SW-1:0] best_far_q, best_near_q;
	logic [CW-1:0] best_x_q, best_y_q;
	logic [CW-1:0] px_q, py_q, ex_q, ey_q;
	logic          rot_q;
	logic [NW-1:0] rp_q, scan_n_q, wp_q, hc_q, k_q, i_q;
	ent_t          p_q, sq_q;

	// Stream pipeline
	logic          rv_s1;
	logic [AW-1:0] ra_s1;
	logic          v_s2, fu_s2, fr_s2;
	logic [SW-1:0] fau_s2, neu_s2, far_s2, ner_s2;
	logic [CW-1:0] x_s2, y_s2;

	// Output register
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [11:0]   pos_x_q, pos_y_q;
	logic          rot_out_q;
	logic [12:0]   aw_q, ah_q;
	logic [8:0]    fc_q;

	// Memory ports
	logic          m_we, s_we;
	logic [AW-1:0] m_waddr, m_raddr, s_waddr;
	ent_t          m_wdata, s_wdata, rd_e, sq;
	logic [EW-1:0] m_rdata, s_rdata;

	// Combinational terms
	logic          stream_st, issue, brk, room, inner_live, hold_pq, hold_qp;
	logic          keep_c, hit_c;
	ent_t          grown_e, push_a_e, push_b_e, pc_e;
	logic          pc_cond, pc_push;
	logic [CW-1:0] sx2, sy2, pw_c, ph_c;
	logic [SW-1:0] dxu, dyu, dxr, dyr, fau, neu, far_c, ner;
	logic          fu, fr, bu, br;
	logic [SW-1:0] f1, n1;

	mrap_ram #(.W(EW), .D(FREE_SLOTS)) u_free (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	mrap_ram #(.W(EW), .D(FREE_SLOTS)) u_hit (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (k_q[AW-1:0]),
		.rdata (s_rdata)
	);

	assign rd_e = ent_t'(m_rdata);
	assign sq   = ent_t'(s_rdata);

	assign req_stall = (state_q != mrap_pkg::S_IDLE);
	assign cfg_ready = (state_q == mrap_pkg::S_IDLE) && !req_valid;

	assign stream_st = state_q inside {mrap_pkg::S_FIT, mrap_pkg::S_CMP,
		mrap_pkg::S_PLACE, mrap_pkg::S_INNER};
	assign issue = stream_st && (rp_q < scan_n_q);
	assign room  = used_q < NW'(FREE_SLOTS);
	assign m_raddr = (state_q == mrap_pkg::S_OUT_RD) ? i_q[AW-1:0] : rp_q[AW-1:0];

	// Pairwise containment against the held outer entry
	assign inner_live = rv_s1 && !rd_e.dead && (rd_e.ow || rd_e.oh);
	assign hold_pq = holds_f(p_q, rd_e);
	assign hold_qp = holds_f(rd_e, p_q);
	assign brk = (state_q == mrap_pkg::S_INNER) && inner_live && !hold_pq && hold_qp;

	// Compaction filter and growth
	assign keep_c = !rd_e.dead && !small_f(rd_e, cap_q);
	always_comb begin
		grown_e = rd_e;
		grown_e.dead = 1'b0;
		if (ctx_q == mrap_pkg::CTX_GROW) begin
			if (rd_e.ow) grown_e.w = rd_e.w + cur_w_q;
			if (rd_e.oh) grown_e.h = rd_e.h + cur_h_q;
		end
	end

	// Entries added by a doubling
	always_comb begin
		push_a_e = '0;
		push_a_e.ow = 1'b1;
		push_a_e.oh = 1'b1;
		push_a_e.x  = cur_w_q;
		push_a_e.w  = cur_w_q;
		push_a_e.h  = {cur_h_q[CW-2:0], 1'b0};
		push_b_e = '0;
		push_b_e.ow = 1'b1;
		push_b_e.oh = 1'b1;
		push_b_e.y  = cur_h_q;
		push_b_e.w  = {cur_w_q[CW-2:0], 1'b0};
		push_b_e.h  = cur_h_q;
	end

	// Overlap of a listed entry with the placed rectangle
	assign hit_c = rd_e.x < ex_q && (rd_e.x + rd_e.w) > px_q &&
		rd_e.y < ey_q && (rd_e.y + rd_e.h) > py_q;

	// Fit terms for both orientations
	always_comb begin
		fu  = rd_e.w >= rw_q && rd_e.h >= rh_q;
		fr  = rd_e.w >= rh_q && rd_e.h >= rw_q;
		dxu = SW'(rd_e.x) + SW'(rw_q);
		dyu = SW'(rd_e.y) + SW'(rh_q);
		dxr = SW'(rd_e.x) + SW'(rh_q);
		dyr = SW'(rd_e.y) + SW'(rw_q);
		fau = (dxu > dyu) ? dxu : dyu;
		neu = (dxu > dyu) ? dyu : dxu;
		far_c = (dxr > dyr) ? dxr : dyr;
		ner = (dxr > dyr) ? dyr : dxr;
	end

	// Best-so-far update, upright first
	always_comb begin
		bu = fu_s2 && (fau_s2 < best_far_q ||
			(fau_s2 == best_far_q && neu_s2 < best_near_q));
		f1 = bu ? fau_s2 : best_far_q;
		n1 = bu ? neu_s2 : best_near_q;
		br = fr_s2 && (far_s2 < f1 || (far_s2 == f1 && ner_s2 < n1));
	end

	assign pw_c = best_rot_q ? rh_q : rw_q;
	assign ph_c = best_rot_q ? rw_q : rh_q;

	// Split piece for the current step
	always_comb begin
		sx2 = sq_q.x + sq_q.w;
		sy2 = sq_q.y + sq_q.h;
		pc_e = '0;
		pc_cond = 1'b0;
		case (piece_q)
			mrap_pkg::PC_ABOVE: begin
				pc_cond = py_q > sq_q.y;
				pc_e.x = sq_q.x;
				pc_e.y = sq_q.y;
				pc_e.w = sq_q.w;
				pc_e.h = py_q - sq_q.y;
			end
			mrap_pkg::PC_BELOW: begin
				pc_cond = ey_q < sy2;
				pc_e.x = sq_q.x;
				pc_e.y = ey_q;
				pc_e.w = sq_q.w;
				pc_e.h = sy2 - ey_q;
			end
			mrap_pkg::PC_LEFT: begin
				pc_cond = px_q > sq_q.x;
				pc_e.x = sq_q.x;
				pc_e.y = sq_q.y;
				pc_e.w = px_q - sq_q.x;
				pc_e.h = sq_q.h;
			end
			mrap_pkg::PC_RIGHT: begin
				pc_cond = ex_q < sx2;
				pc_e.x = ex_q;
				pc_e.y = sq_q.y;
				pc_e.w = sx2 - ex_q;
				pc_e.h = sq_q.h;
			end
			default: ;
		endcase
		pc_e.ow = (pc_e.x + pc_e.w) == cur_w_q;
		pc_e.oh = (pc_e.y + pc_e.h) == cur_h_q;
		pc_push = pc_cond && !small_f(pc_e, cap_q);
	end

	// Memory write selection
	always_comb begin
		m_we = 1'b0;
		m_waddr = '0;
		m_wdata = '0;
		s_we = 1'b0;
		s_waddr = hc_q[AW-1:0];
		s_wdata = rd_e;
		case (state_q)
			mrap_pkg::S_INIT: begin
				m_we = 1'b1;
				m_wdata.ow = 1'b1;
				m_wdata.oh = 1'b1;
				m_wdata.w = CW'(START_SIZE);
				m_wdata.h = CW'(START_SIZE);
			end
			mrap_pkg::S_CMP: begin
				m_we = rv_s1 && keep_c;
				m_waddr = wp_q[AW-1:0];
				m_wdata = grown_e;
			end
			mrap_pkg::S_PUSH_A: begin
				m_we = room;
				m_waddr = used_q[AW-1:0];
				m_wdata = push_a_e;
			end
			mrap_pkg::S_PUSH_B: begin
				m_we = room;
				m_waddr = used_q[AW-1:0];
				m_wdata = push_b_e;
			end
			mrap_pkg::S_PLACE: begin
				m_we = rv_s1 && !hit_c;
				m_waddr = wp_q[AW-1:0];
				m_wdata = rd_e;
				s_we = rv_s1 && hit_c;
			end
			mrap_pkg::S_PIECE: begin
				m_we = pc_push && room;
				m_waddr = used_q[AW-1:0];
				m_wdata = pc_e;
			end
			mrap_pkg::S_INNER: begin
				if (inner_live && hold_pq) begin
					m_we = 1'b1;
					m_waddr = ra_s1;
					m_wdata = rd_e;
					m_wdata.dead = 1'b1;
				end else if (brk) begin
					m_we = 1'b1;
					m_waddr = i_q[AW-1:0];
					m_wdata = p_q;
					m_wdata.dead = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Stream pipeline payload
	always_ff @(posedge clk) begin
		ra_s1  <= rp_q[AW-1:0];
		fu_s2  <= fu;
		fr_s2  <= fr;
		fau_s2 <= fau;
		neu_s2 <= neu;
		far_s2 <= far_c;
		ner_s2 <= ner;
		x_s2   <= rd_e.x;
		y_s2   <= rd_e.y;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mrap_pkg::S_INIT;
			ctx_q        <= mrap_pkg::CTX_PRE;
			piece_q      <= mrap_pkg::PC_ABOVE;
			clean_cfg_q  <= 1'b0;
			used_q       <= NW'(1);
			cur_w_q      <= CW'(START_SIZE);
			cur_h_q      <= CW'(START_SIZE);
			cap_q        <= 13'd1;
			grow_en_q    <= 1'b1;
			lost_q       <= 1'b0;
			placed_q     <= 1'b0;
			best_found_q <= 1'b0;
			best_rot_q   <= 1'b0;
			rp_q         <= '0;
			scan_n_q     <= '0;
			wp_q         <= '0;
			hc_q         <= '0;
			k_q          <= '0;
			i_q          <= '0;
			rv_s1        <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rv_s1 <= issue && !brk;
			v_s2  <= rv_s1 && (state_q == mrap_pkg::S_FIT);
			if (issue) rp_q <= rp_q + NW'(1);
			// drop a transferred result unless a new one is loaded below
			if (out_valid_q && !res_stall && state_q != mrap_pkg::S_RESULT)
				out_valid_q <= 1'b0;

			// fold one search candidate into the best choice
			if (v_s2) begin
				if (br) begin
					best_found_q <= 1'b1;
					best_rot_q   <= 1'b1;
					best_far_q   <= far_s2;
					best_near_q  <= ner_s2;
					best_x_q     <= x_s2;
					best_y_q     <= y_s2;
				end else if (bu) begin
					best_found_q <= 1'b1;
					best_rot_q   <= 1'b0;
					best_far_q   <= fau_s2;
					best_near_q  <= neu_s2;
					best_x_q     <= x_s2;
					best_y_q     <= y_s2;
				end
			end

			case (state_q)
				mrap_pkg::S_INIT: begin
					state_q <= mrap_pkg::S_IDLE;
				end
				mrap_pkg::S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						case (cfg_index)
							mrap_pkg::REG_SIZE_CAP: begin
								cap_q       <= cfg_data;
								ctx_q       <= mrap_pkg::CTX_PRE;
								clean_cfg_q <= 1'b1;
								rp_q        <= '0;
								wp_q        <= '0;
								scan_n_q    <= used_q;
								state_q     <= mrap_pkg::S_CMP;
							end
							mrap_pkg::REG_AUTO_GROW: grow_en_q <= cfg_data[0];
							default: ;
						endcase
					end else if (req_valid) begin
						rw_q        <= CW'(rect_width);
						rh_q        <= CW'(rect_height);
						lost_q      <= 1'b0;
						placed_q    <= 1'b0;
						clean_cfg_q <= 1'b0;
						if (rect_width == 13'd0 || rect_height == 13'd0)
							state_q <= mrap_pkg::S_RESULT;
						else
							state_q <= mrap_pkg::S_FIT_INIT;
					end
				end
				mrap_pkg::S_FIT_INIT: begin
					best_far_q   <= SW'(cur_w_q) + SW'(1);
					best_near_q  <= SW'(cur_w_q) + SW'(1);
					best_found_q <= 1'b0;
					best_rot_q   <= 1'b0;
					rp_q         <= '0;
					scan_n_q     <= used_q;
					state_q      <= mrap_pkg::S_FIT;
				end
				mrap_pkg::S_FIT: begin
					if (rp_q == scan_n_q && !rv_s1 && !v_s2) state_q <= mrap_pkg::S_FIT_END;
				end
				mrap_pkg::S_FIT_END: begin
					if (best_found_q) begin
						px_q     <= best_x_q;
						py_q     <= best_y_q;
						ex_q     <= best_x_q + pw_c;
						ey_q     <= best_y_q + ph_c;
						rot_q    <= best_rot_q;
						placed_q <= 1'b1;
						rp_q     <= '0;
						wp_q     <= '0;
						hc_q     <= '0;
						scan_n_q <= used_q;
						state_q  <= mrap_pkg::S_PLACE;
					end else if (grow_en_q && cur_w_q < CW'(MAX_ATLAS)) begin
						ctx_q    <= mrap_pkg::CTX_GROW;
						rp_q     <= '0;
						wp_q     <= '0;
						scan_n_q <= used_q;
						state_q  <= mrap_pkg::S_CMP;
					end else begin
						state_q <= mrap_pkg::S_RESULT;
					end
				end
				mrap_pkg::S_CMP: begin
					if (rv_s1 && keep_c) wp_q <= wp_q + NW'(1);
					if (rp_q == scan_n_q && !rv_s1) begin
						used_q <= wp_q;
						case (ctx_q)
							mrap_pkg::CTX_GROW: state_q <= mrap_pkg::S_PUSH_A;
							mrap_pkg::CTX_PRE: begin
								i_q     <= '0;
								state_q <= mrap_pkg::S_OUT_RD;
							end
							mrap_pkg::CTX_POST:
								state_q <= clean_cfg_q ? mrap_pkg::S_IDLE : mrap_pkg::S_RESULT;
							default: state_q <= mrap_pkg::S_IDLE;
						endcase
					end
				end
				mrap_pkg::S_PUSH_A: begin
					if (room) used_q <= used_q + NW'(1);
					else lost_q <= 1'b1;
					state_q <= mrap_pkg::S_PUSH_B;
				end
				mrap_pkg::S_PUSH_B: begin
					if (room) used_q <= used_q + NW'(1);
					else lost_q <= 1'b1;
					cur_w_q <= {cur_w_q[CW-2:0], 1'b0};
					cur_h_q <= {cur_h_q[CW-2:0], 1'b0};
					state_q <= mrap_pkg::S_FIT_INIT;
				end
				mrap_pkg::S_PLACE: begin
					if (rv_s1) begin
						if (hit_c) hc_q <= hc_q + NW'(1);
						else wp_q <= wp_q + NW'(1);
					end
					if (rp_q == scan_n_q && !rv_s1) begin
						used_q  <= wp_q;
						k_q     <= '0;
						state_q <= mrap_pkg::S_PIECE_RD;
					end
				end
				mrap_pkg::S_PIECE_RD: begin
					if (k_q == hc_q) begin
						ctx_q    <= mrap_pkg::CTX_PRE;
						rp_q     <= '0;
						wp_q     <= '0;
						scan_n_q <= used_q;
						state_q  <= mrap_pkg::S_CMP;
					end else begin
						state_q <= mrap_pkg::S_PIECE_WT;
					end
				end
				mrap_pkg::S_PIECE_WT: begin
					sq_q    <= sq;
					piece_q <= mrap_pkg::PC_ABOVE;
					state_q <= mrap_pkg::S_PIECE;
				end
				mrap_pkg::S_PIECE: begin
					if (pc_push) begin
						if (room) used_q <= used_q + NW'(1);
						else lost_q <= 1'b1;
					end
					if (piece_q == mrap_pkg::PC_RIGHT) begin
						k_q     <= k_q + NW'(1);
						state_q <= mrap_pkg::S_PIECE_RD;
					end else begin
						piece_q <= mrap_pkg::piece_t'(piece_q + 2'd1);
					end
				end
				mrap_pkg::S_OUT_RD: begin
					if ((i_q + NW'(1)) >= used_q) begin
						ctx_q    <= mrap_pkg::CTX_POST;
						rp_q     <= '0;
						wp_q     <= '0;
						scan_n_q <= used_q;
						state_q  <= mrap_pkg::S_CMP;
					end else begin
						state_q <= mrap_pkg::S_OUT_WT;
					end
				end
				mrap_pkg::S_OUT_WT: begin
					p_q <= rd_e;
					if (rd_e.dead || (!rd_e.ow && !rd_e.oh)) begin
						i_q     <= i_q + NW'(1);
						state_q <= mrap_pkg::S_OUT_RD;
					end else begin
						rp_q     <= i_q + NW'(1);
						scan_n_q <= used_q;
						state_q  <= mrap_pkg::S_INNER;
					end
				end
				mrap_pkg::S_INNER: begin
					if (brk || (rp_q == scan_n_q && !rv_s1)) begin
						i_q     <= i_q + NW'(1);
						state_q <= mrap_pkg::S_OUT_RD;
					end
				end
				mrap_pkg::S_RESULT: begin
					if (!out_valid_q || !res_stall) begin
						out_valid_q <= 1'b1;
						status_q  <= placed_q ? (lost_q ? mrap_pkg::STAT_OVF : mrap_pkg::STAT_PLACED)
							: mrap_pkg::STAT_NOFIT;
						pos_x_q   <= placed_q ? 12'(px_q) : 12'd0;
						pos_y_q   <= placed_q ? 12'(py_q) : 12'd0;
						rot_out_q <= placed_q && rot_q;
						aw_q      <= cur_w_q[12:0];
						ah_q      <= cur_h_q[12:0];
						fc_q      <= 9'(used_q);
						state_q   <= mrap_pkg::S_IDLE;
					end
				end
				default: state_q <= mrap_pkg::S_IDLE;
			endcase
		end
	end

	assign res_valid    = out_valid_q;
	assign status       = status_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign rotated      = rot_out_q;
	assign atlas_width  = aw_q;
	assign atlas_height = ah_q;
	assign free_count   = fc_q;

endmodule

### verif/maxrects_atlas_packer_checker.sv
module maxrects_atlas_packer_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  logic                                 req_stall,
	input  logic [12:0]                          rect_width,
	input  logic [12:0]                          rect_height,
	input  logic                                 res_valid,
	input  logic                                 res_stall,
	input  logic [1:0]                           status,
	input  logic [11:0]                          pos_x,
	input  logic [11:0]                          pos_y,
	input  logic                                 rotated,
	input  logic [12:0]                          atlas_width,
	input  logic [12:0]                          atlas_height,
	input  logic [8:0]                           free_count,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [mrap_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [12:0]                          cfg_data,
	output int                                   errors,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ATLAS_LIMIT = 4096;
	localparam int ATLAS_START = 32;
	localparam int SLOTS       = 256;

	typedef struct {
		int unsigned x, y, w, h;
		bit          ow, oh;
	} span_t;

	typedef struct {
		logic [1:0]  status;
		logic [11:0] px, py;
		logic        rot;
		logic [12:0] aw, ah;
		logic [8:0]  cnt;
	} placement_t;

	span_t        spans[SLOTS];
	span_t        spans_prev[SLOTS];
	int unsigned  span_cnt, atlas_w, atlas_h, min_edge;
	bit           grow_en, span_lost;
	int           best_idx;
	bit           best_rot;
	int unsigned  best_far, best_near;
	placement_t   placements_due[$];

	assign pending = placements_due.size();

	function automatic void span_push(span_t e);
		if (span_cnt < SLOTS) begin
			spans[span_cnt] = e;
			span_cnt++;
		end else begin
			span_lost = 1;
		end
	endfunction

	function automatic void span_remove(int unsigned k);
		for (int unsigned i = k; i + 1 < span_cnt; i++)
			spans[i] = spans[i + 1];
		span_cnt--;
	endfunction

	function automatic bit undersized(span_t e);
		return (e.w < min_edge && !e.ow) || (e.h < min_edge && !e.oh);
	endfunction

	function automatic void drop_undersized();
		int unsigned n;
		n = 0;
		for (int unsigned i = 0; i < span_cnt; i++)
			if (!undersized(spans[i])) begin
				spans[n] = spans[i];
				n++;
			end
		span_cnt = n;
	endfunction

	function automatic bit encloses(span_t p, span_t c);
		return c.x >= p.x && c.y >= p.y && c.x + c.w <= p.x + p.w && c.y + c.h <= p.y + p.h;
	endfunction

	// Drop small entries, then prune open entries held in another open entry
	function automatic void tidy_spans();
		int unsigned i, j;
		bit gone;
		drop_undersized();
		i = 0;
		while (i + 1 < span_cnt) begin
			if (!spans[i].ow && !spans[i].oh) begin
				i++;
				continue;
			end
			gone = 0;
			j = i + 1;
			while (j < span_cnt) begin
				if (!spans[j].ow && !spans[j].oh) begin
					j++;
				end else if (encloses(spans[i], spans[j])) begin
					span_remove(j);
				end else if (encloses(spans[j], spans[i])) begin
					span_remove(i);
					gone = 1;
					break;
				end else begin
					j++;
				end
			end
			if (!gone)
				i++;
		end
	endfunction

	function automatic bit double_atlas();
		span_t e;
		if (atlas_w >= ATLAS_LIMIT)
			return 0;
		drop_undersized();
		for (int unsigned i = 0; i < span_cnt; i++) begin
			if (spans[i].ow) spans[i].w += atlas_w;
			if (spans[i].oh) spans[i].h += atlas_h;
		end
		e.ow = 1;
		e.oh = 1;
		e.x = atlas_w; e.y = 0; e.w = atlas_w; e.h = atlas_h * 2;
		span_push(e);
		e.x = 0; e.y = atlas_h; e.w = atlas_w * 2; e.h = atlas_h;
		span_push(e);
		atlas_w *= 2;
		atlas_h *= 2;
		return 1;
	endfunction

	function automatic void try_span(int unsigned i, int unsigned pw, int unsigned ph, bit rot);
		int unsigned dx, dy, fa, ne;
		if (spans[i].w < pw || spans[i].h < ph)
			return;
		dx = spans[i].x + pw;
		dy = spans[i].y + ph;
		fa = dx > dy ? dx : dy;
		ne = dx > dy ? dy : dx;
		if (fa < best_far || (fa == best_far && ne < best_near)) begin
			best_idx = int'(i);
			best_rot = rot;
			best_far = fa;
			best_near = ne;
		end
	endfunction

	function automatic void search_fit(int unsigned rw, int unsigned rh);
		best_idx = -1;
		best_rot = 0;
		best_far = atlas_w + 1;
		best_near = best_far;
		for (int unsigned i = 0; i < span_cnt; i++) begin
			try_span(i, rw, rh, 0);
			try_span(i, rh, rw, 1);
		end
	endfunction

	function automatic void add_split(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h);
		span_t e;
		e.x = x; e.y = y; e.w = w; e.h = h;
		e.ow = (x + w == atlas_w);
		e.oh = (y + h == atlas_h);
		if ((w >= min_edge || e.ow) && (h >= min_edge || e.oh))
			span_push(e);
	endfunction

	// Keep untouched entries, then split every overlapped one into up to four side pieces
	function automatic void carve(int unsigned px, int unsigned py, int unsigned pw,
			int unsigned ph);
		int unsigned n, ex, ey, sx2, sy2;
		bit hit[SLOTS];
		n = span_cnt;
		ex = px + pw;
		ey = py + ph;
		for (int unsigned i = 0; i < n; i++)
			spans_prev[i] = spans[i];
		span_cnt = 0;
		for (int unsigned i = 0; i < n; i++) begin
			hit[i] = spans_prev[i].x < ex && spans_prev[i].x + spans_prev[i].w > px &&
				spans_prev[i].y < ey && spans_prev[i].y + spans_prev[i].h > py;
			if (!hit[i]) begin
				spans[span_cnt] = spans_prev[i];
				span_cnt++;
			end
		end
		for (int unsigned i = 0; i < n; i++) begin
			if (!hit[i])
				continue;
			sx2 = spans_prev[i].x + spans_prev[i].w;
			sy2 = spans_prev[i].y + spans_prev[i].h;
			if (py > spans_prev[i].y)
				add_split(spans_prev[i].x, spans_prev[i].y, spans_prev[i].w, py - spans_prev[i].y);
			if (ey < sy2)
				add_split(spans_prev[i].x, ey, spans_prev[i].w, sy2 - ey);
			if (px > spans_prev[i].x)
				add_split(spans_prev[i].x, spans_prev[i].y, px - spans_prev[i].x, spans_prev[i].h);
			if (ex < sx2)
				add_split(ex, spans_prev[i].y, sx2 - ex, spans_prev[i].h);
		end
	endfunction

	function automatic placement_t pack_rect(int unsigned rw, int unsigned rh);
		placement_t r;
		int unsigned px, py;
		r.status = mrap_pkg::STAT_NOFIT;
		r.px = '0;
		r.py = '0;
		r.rot = 0;
		span_lost = 0;
		if (rw != 0 && rh != 0) begin
			search_fit(rw, rh);
			while (grow_en && best_idx < 0) begin
				if (!double_atlas())
					break;
				search_fit(rw, rh);
			end
			if (best_idx >= 0 && best_idx < span_cnt) begin
				px = spans[best_idx].x;
				py = spans[best_idx].y;
				r.px = px[11:0];
				r.py = py[11:0];
				r.rot = best_rot;
				if (best_rot) carve(px, py, rh, rw);
				else carve(px, py, rw, rh);
				tidy_spans();
				r.status = span_lost ? mrap_pkg::STAT_OVF : mrap_pkg::STAT_PLACED;
			end
		end
		r.aw = atlas_w[12:0];
		r.ah = atlas_h[12:0];
		r.cnt = span_cnt[8:0];
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Track config and requests, compare each result against the oldest placement
	always @(posedge clk or negedge arst_n) begin
		placement_t exp_p;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				spans[i] = '{default: 0};
			spans[0].w = ATLAS_START;
			spans[0].h = ATLAS_START;
			spans[0].ow = 1;
			spans[0].oh = 1;
			span_cnt = 1;
			atlas_w = ATLAS_START;
			atlas_h = ATLAS_START;
			min_edge = 1;
			grow_en = 1;
			errors = 0;
			placements_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mrap_pkg::REG_SIZE_CAP) begin
					min_edge = cfg_data;
					tidy_spans();
				end else if (cfg_index == mrap_pkg::REG_AUTO_GROW) begin
					grow_en = cfg_data[0];
				end
			end
			if (req_valid && !req_stall)
				placements_due.insert(placements_due.size(), pack_rect(rect_width, rect_height));
			if (res_valid && !res_stall) begin
				if (placements_due.size() == 0) begin
					errors++;
					$display("%0t: result transfer with no placement due", $time);
				end else begin
					exp_p = placements_due.pop_front();
					check_field("status", exp_p.status, status);
					check_field("pos_x", exp_p.px, pos_x);
					check_field("pos_y", exp_p.py, pos_y);
					check_field("rotated", exp_p.rot, rotated);
					check_field("atlas_width", exp_p.aw, atlas_width);
					check_field("atlas_height", exp_p.ah, atlas_height);
					check_field("free_count", exp_p.cnt, free_count);
				end
			end
		end
	end

endmodule

### verif/maxrects_atlas_packer_tb.sv
module maxrects_atlas_packer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 600000;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic [12:0]          rect_width;
	logic [12:0]          rect_height;
	logic                 res_valid;
	logic                 res_stall;
	logic [1:0]           status;
	logic [11:0]          pos_x;
	logic [11:0]          pos_y;
	logic                 rotated;
	logic [12:0]          atlas_width;
	logic [12:0]          atlas_height;
	logic [8:0]           free_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [mrap_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [12:0]          cfg_data;
	int                   errors;
	int                   pending;
	int                   idle_cycles = 0;
	int                   stall_left;
	int                   rects_sent;
	int                   results_seen;
	bit                   gaps_on;

	maxrects_atlas_packer DUT (.*);

	maxrects_atlas_packer_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Stall the result side for a random count after each transfer while gaps_on is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
			results_seen = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (res_valid && !res_stall) begin
			results_seen++;
			stall_left = gaps_on ? $urandom_range(0, 10) : 0;
			res_stall <= (stall_left > 0);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Count cycles with no transfer on any channel and fail the run at STALL_LIMIT
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_rect(int unsigned w, int unsigned h);
		int gap;
		gap = gaps_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		rect_width <= w[12:0];
		rect_height <= h[12:0];
		do @(posedge clk); while (req_stall);
		rects_sent++;
	endtask

	// Drain, let the packer settle, then write one register
	task automatic write_reg(logic [mrap_pkg::CFG_IDX_W-1:0] idx, logic [12:0] val);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_rects(int count, int unsigned top);
		int unsigned w, h;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(1, top);
				h = $urandom_range(1, top);
			end else begin
				w = $urandom_range(1, 24);
				h = $urandom_range(1, 24);
			end
			send_rect(w, h);
		end
	endtask

	initial begin
		req_valid = 1'b0;
		rect_width = '0;
		rect_height = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rects_sent = 0;
		gaps_on = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: tiny, rotated, forced growth and zero-size requests
		send_rect(1, 1);
		send_rect(2, 1);
		send_rect(1, 2);
		send_rect(33, 5);
		send_rect(0, 7);
		send_rect(7, 0);
		send_rect(40, 20);
		send_rect(20, 40);
		gaps_on = 1'b1;
		random_rects(12, 64);

		// No growth: oversize requests miss
		write_reg(mrap_pkg::REG_AUTO_GROW, 13'd0);
		write_reg(mrap_pkg::REG_SIZE_CAP, 13'd4);
		send_rect(100, 100);
		send_rect(1, 1);
		random_rects(25, 200);

		// Zero cap keeps every piece, growth back on
		write_reg(mrap_pkg::REG_SIZE_CAP, 13'd0);
		write_reg(mrap_pkg::REG_AUTO_GROW, 13'd1);
		gaps_on = 1'b0;
		random_rects(20, 512);

		// Cap at the atlas ceiling drops closed pieces; hit the growth ceiling
		write_reg(mrap_pkg::REG_SIZE_CAP, 13'd4096);
		gaps_on = 1'b1;
		send_rect(4095, 1);
		send_rect(4096, 4096);
		send_rect(4096, 4096);
		send_rect(4096, 1);
		random_rects(15, 4096);

		// Random cap and growth
		write_reg(mrap_pkg::REG_SIZE_CAP, 13'($urandom_range(1, 16)));
		write_reg(mrap_pkg::REG_AUTO_GROW, 13'($urandom_range(0, 1)));
		random_rects(15, 4096);

		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		$display("Packed %0d rectangles across five register settings, %0d results checked",
			rects_sent, results_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
design/mrap_pkg.sv
design/mrap_ram.sv
design/maxrects_atlas_packer.sv
verif/maxrects_atlas_packer_checker.sv
verif/maxrects_atlas_packer_tb.sv
